// ----- src/cros_pkg.sv -----
// Shared types and fixed constants for the chord row order sorter.
// Used by cros_prep, cros_cell and chord_row_order_sorter; depends on nothing.
package cros_pkg;

   // Fixed widths of the result fields.
   localparam int INDEX_BITS    = 5;
   localparam int RSP_DATA_BITS = 8;
   localparam int RSP_USER_BITS = 2;

   // Bit positions inside rsp_tuser.
   localparam int USER_EMPTY    = 0;
   localparam int USER_OVERFLOW = 1;

   // Status of the box held in the area stage.
   typedef struct packed {
      logic valid;
      logic keep;
      logic last;
   } stage_ctl_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctl_type;

endpackage

// ----- src/cros_prep.sv -----
// Front stage of the chord row order sorter: box check and area multiply,
// registered once. Depends on cros_pkg.
module cros_prep #(
   parameter int COORD_BITS = 12,
   localparam int AREA_BITS = 2 * COORD_BITS + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [COORD_BITS-1:0]     box_left,
   input  logic [COORD_BITS-1:0]     box_top,
   input  logic [COORD_BITS:0]       box_right,
   input  logic [COORD_BITS:0]       box_bottom,
   input  logic                      batch_end,
   output cros_pkg::stage_ctl_type   stage,
   output logic [COORD_BITS-1:0]     stage_top,
   output logic [AREA_BITS-1:0]      stage_area
);

   localparam int PROD_BITS = 2 * (COORD_BITS + 1);

   logic                  keep_w;
   logic [COORD_BITS:0]   width_w;
   logic [COORD_BITS:0]   height_w;
   logic [PROD_BITS-1:0]  prod_w;
   logic [AREA_BITS-1:0]  area_w;

   cros_pkg::stage_ctl_type stage_ff;
   logic [COORD_BITS-1:0]   top_ff;
   logic [AREA_BITS-1:0]    area_ff;

   assign keep_w   = (box_right > {1'b0, box_left}) && (box_bottom > {1'b0, box_top});
   assign width_w  = box_right - {1'b0, box_left};
   assign height_w = box_bottom - {1'b0, box_top};
   assign prod_w   = PROD_BITS'(width_w) * PROD_BITS'(height_w);

   // Only a right or bottom edge above 2**COORD_BITS can reach the top product bit.
   assign area_w = prod_w[PROD_BITS-1] ? '1 : prod_w[AREA_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff.valid <= accept;
         stage_ff.keep  <= keep_w;
         stage_ff.last  <= batch_end;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         top_ff  <= box_top;
         area_ff <= area_w;
      end
   end

   assign stage      = stage_ff;
   assign stage_top  = top_ff;
   assign stage_area = area_ff;

endmodule

// ----- src/cros_cell.sv -----
// One slot of the sorting chain: holds a kept entry, shifts right on insert
// and left on drain. Depends on cros_pkg.
module cros_cell #(
   parameter int TOP_BITS  = 12,
   parameter int AREA_BITS = 25,
   parameter int IDX_BITS  = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cros_pkg::cell_ctl_type ctl,
   input  logic [TOP_BITS-1:0]    new_top,
   input  logic [AREA_BITS-1:0]   new_area,
   input  logic [IDX_BITS-1:0]    new_index,
   input  logic                   left_valid,
   input  logic                   left_move,
   input  logic [TOP_BITS-1:0]    left_top,
   input  logic [AREA_BITS-1:0]   left_area,
   input  logic [IDX_BITS-1:0]    left_index,
   input  logic                   right_valid,
   input  logic [TOP_BITS-1:0]    right_top,
   input  logic [AREA_BITS-1:0]   right_area,
   input  logic [IDX_BITS-1:0]    right_index,
   output logic                   valid,
   output logic                   move,
   output logic [TOP_BITS-1:0]    top,
   output logic [AREA_BITS-1:0]   area,
   output logic [IDX_BITS-1:0]    index
);

   logic                 valid_ff;
   logic [TOP_BITS-1:0]  top_ff;
   logic [AREA_BITS-1:0] area_ff;
   logic [IDX_BITS-1:0]  index_ff;

   logic before_w;
   logic move_w;
   logic load_w;

   // The new box goes strictly ahead of this entry; ties stay behind.
   assign before_w = (new_top < top_ff) || ((new_top == top_ff) && (new_area > area_ff));
   assign move_w   = valid_ff && before_w;

   // Take the new box where the left neighbor stays put and this slot either
   // moves on or is the first free one.
   assign load_w = !left_move && (move_w || (!valid_ff && left_valid));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.drain) begin
         valid_ff <= right_valid;
      end else if (ctl.insert && (left_move || load_w)) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.drain) begin
         top_ff   <= right_top;
         area_ff  <= right_area;
         index_ff <= right_index;
      end else if (ctl.insert && left_move) begin
         top_ff   <= left_top;
         area_ff  <= left_area;
         index_ff <= left_index;
      end else if (ctl.insert && load_w) begin
         top_ff   <= new_top;
         area_ff  <= new_area;
         index_ff <= new_index;
      end
   end

   assign valid = valid_ff;
   assign move  = move_w;
   assign top   = top_ff;
   assign area  = area_ff;
   assign index = index_ff;

endmodule

// ----- src/chord_row_order_sorter.sv -----
// Top level of the chord row order sorter: area stage, chain of sorting
// cells and the batch controller. Depends on cros_pkg, cros_prep, cros_cell.
//
//  Channel   Direction  Handshake        Payload
//  req_      in         tvalid/tready    tdata: box fields, tlast: batch_end
//  rsp_      out        tvalid/tready    tdata: chord_index, tlast: run_last,
//                                        tuser: batch_empty, overflowed
//
// Boxes are taken one per cycle while req_tready is high: the area multiply stage
// registers each one, then every cell compares against the new box and the chain
// shifts to open its slot. After the batch-end request reaches the chain,
// results leave one per cycle from the head cell at full rsp_tready; an empty
// batch gives a single result, flagged as batch_empty.
// req_tready is low from the cycle the batch-end request sits in the area
// stage until the last result is taken. A stalled rsp_ holds the chain.
// Reset clears the cell valid bits, the count, the overflow flag and the
// controller; entry payloads are not cleared.
module chord_row_order_sorter #(
   parameter int CAPACITY   = 32,
   parameter int COORD_BITS = 12,
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 2 + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // box_left, box_top, box_right, box_bottom from bit 0 up, zero padded
   input  logic [REQ_DATA_BITS-1:0]             req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // chord_index from bit 0, zero padded
   output logic [cros_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   // batch_empty at bit 0, overflowed at bit 1
   output logic [cros_pkg::RSP_USER_BITS-1:0]   rsp_tuser
);

   localparam int AREA_BITS  = 2 * COORD_BITS + 1;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int IDX_BITS   = cros_pkg::INDEX_BITS;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type                state_ff;
   logic [COUNT_BITS-1:0]    count_ff;
   logic                     ovf_ff;
   logic                     empty_ff;

   logic                     req_accept;
   logic                     rsp_accept;
   logic                     full_w;
   logic                     do_insert;
   logic [IDX_BITS-1:0]      new_index;

   cros_pkg::stage_ctl_type  stage;
   logic [COORD_BITS-1:0]    stage_top;
   logic [AREA_BITS-1:0]     stage_area;
   cros_pkg::cell_ctl_type   cell_ctl;

   logic [CAPACITY-1:0]      c_valid;
   logic [CAPACITY-1:0]      c_move;
   logic [COORD_BITS-1:0]    c_top   [CAPACITY];
   logic [AREA_BITS-1:0]     c_area  [CAPACITY];
   logic [IDX_BITS-1:0]      c_index [CAPACITY];

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   cros_prep #(
      .COORD_BITS (COORD_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .box_left   (req_tdata[COORD_BITS-1:0]),
      .box_top    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .box_right  (req_tdata[3*COORD_BITS:2*COORD_BITS]),
      .box_bottom (req_tdata[4*COORD_BITS+1:3*COORD_BITS+1]),
      .batch_end  (req_tlast),
      .stage      (stage),
      .stage_top  (stage_top),
      .stage_area (stage_area)
   );

   assign full_w    = c_valid[CAPACITY-1];
   assign do_insert = (state_ff == ST_LOAD) && stage.valid && stage.keep && !full_w;
   assign new_index = IDX_BITS'(count_ff);

   assign cell_ctl.insert = do_insert;
   assign cell_ctl.drain  = rsp_accept && !empty_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  l_valid;
      logic                  l_move;
      logic [COORD_BITS-1:0] l_top;
      logic [AREA_BITS-1:0]  l_area;
      logic [IDX_BITS-1:0]   l_index;
      logic                  r_valid;
      logic [COORD_BITS-1:0] r_top;
      logic [AREA_BITS-1:0]  r_area;
      logic [IDX_BITS-1:0]   r_index;

      // The head cell sees a settled, occupied neighbor on its left.
      if (i == 0) begin : g_head
         assign l_valid = 1'b1;
         assign l_move  = 1'b0;
         assign l_top   = '0;
         assign l_area  = '0;
         assign l_index = '0;
      end else begin : g_body
         assign l_valid = c_valid[i-1];
         assign l_move  = c_move[i-1];
         assign l_top   = c_top[i-1];
         assign l_area  = c_area[i-1];
         assign l_index = c_index[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_top   = '0;
         assign r_area  = '0;
         assign r_index = '0;
      end else begin : g_link
         assign r_valid = c_valid[i+1];
         assign r_top   = c_top[i+1];
         assign r_area  = c_area[i+1];
         assign r_index = c_index[i+1];
      end

      cros_cell #(
         .TOP_BITS  (COORD_BITS),
         .AREA_BITS (AREA_BITS),
         .IDX_BITS  (IDX_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .new_top     (stage_top),
         .new_area    (stage_area),
         .new_index   (new_index),
         .left_valid  (l_valid),
         .left_move   (l_move),
         .left_top    (l_top),
         .left_area   (l_area),
         .left_index  (l_index),
         .right_valid (r_valid),
         .right_top   (r_top),
         .right_area  (r_area),
         .right_index (r_index),
         .valid       (c_valid[i]),
         .move        (c_move[i]),
         .top         (c_top[i]),
         .area        (c_area[i]),
         .index       (c_index[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (do_insert) begin
                  count_ff <= count_ff + COUNT_BITS'(1);
               end
               if (stage.valid && stage.keep && full_w) begin
                  ovf_ff <= 1'b1;
               end
               if (stage.valid && stage.last) begin
                  state_ff <= ST_DRAIN;
                  empty_ff <= (count_ff == '0) && !do_insert;
               end
            end
            ST_DRAIN: begin
               if (rsp_accept && rsp_tlast) begin
                  state_ff <= ST_LOAD;
                  count_ff <= '0;
                  ovf_ff   <= 1'b0;
                  empty_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   // Hold off new boxes while a batch end is in flight or results drain.
   assign req_tready = (state_ff == ST_LOAD) && !(stage.valid && stage.last);

   assign rsp_tvalid = (state_ff == ST_DRAIN);
   assign rsp_tdata  = cros_pkg::RSP_DATA_BITS'(empty_ff ? '0 : c_index[0]);
   assign rsp_tlast  = empty_ff || !c_valid[1];
   assign rsp_tuser[cros_pkg::USER_EMPTY]    = empty_ff;
   assign rsp_tuser[cros_pkg::USER_OVERFLOW] = ovf_ff;

   // Occupied cells always form an unbroken run from the head.
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (c_valid & (c_valid + CAPACITY'(1))) == '0)
      else $error("cell chain has a gap");

   // While loading, the count tracks the number of occupied cells.
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (count_ff == COUNT_BITS'($countones(c_valid))))
      else $error("entry count differs from occupied cells");

   // An empty-batch result is only shown when the chain holds nothing.
   a_empty_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[cros_pkg::USER_EMPTY]) |-> !c_valid[0])
      else $error("empty result with occupied chain");

   // Taking the final result leaves the chain empty.
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_tlast) |=> (c_valid == '0))
      else $error("entries left after final result");

endmodule
